// ===== rtl/dch_pkg.sv =====
// Shared types and constants of the detector coincidence histogrammer.
package dch_pkg;

   // Three detector planes report per event.
   localparam int UNIT_COUNT = 3;
   // Coincidence types: pairs 01, 02, 12 and the triple 012.
   localparam int TYPE_COUNT = 4;

   // Event counter layout.
   localparam int COUNTER_NUM = 13;
   localparam int CNT_COINC_BASE = 0;
   localparam int CNT_SINGLE_BASE = 4;
   localparam int CNT_FEW_HITS_BASE = 8;
   localparam int CNT_EVENTS = 12;

   // Width of a position difference magnitude (at most 2046).
   localparam int MAG_W = 11;

   typedef logic [1:0] unit_idx_type;
   typedef logic [UNIT_COUNT-1:0] unit_mask_type;

   // Units taking part in each coincidence type.
   localparam unit_mask_type TYPE_UNITS [TYPE_COUNT] = '{3'b011, 3'b101, 3'b110, 3'b111};
   // Units whose positions form dx and dy for each pair selection.
   localparam unit_idx_type FIRST_UNIT [TYPE_COUNT] = '{2'd0, 2'd0, 2'd1, 2'd0};
   localparam unit_idx_type SECOND_UNIT [TYPE_COUNT] = '{2'd1, 2'd2, 2'd2, 2'd2};

   typedef enum logic [1:0] {
      OP_REPORT       = 2'd0,
      OP_HIST_READ    = 2'd1,
      OP_COUNTER_READ = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_EVENT   = 2'd0,
      KIND_HIST    = 2'd1,
      KIND_COUNTER = 2'd2
   } kind_type;

   // One unit report as kept between requests of an event.
   typedef struct packed {
      logic [7:0] data_count;
      logic [7:0] x_hits;
      logic [7:0] x_clusters;
      logic [9:0] x_center;
      logic [7:0] y_hits;
      logic [7:0] y_clusters;
      logic [9:0] y_center;
   } unit_rec_type;

   // An incoming request.
   typedef struct packed {
      logic [1:0]   opcode;
      unit_idx_type unit;
      unit_rec_type rec;
      logic         event_end;
      logic [15:0]  read_index;
   } req_type;

   // Configuration registers.
   typedef struct packed {
      logic [1:0]    pair_select;
      logic [7:0]    max_hits;
      logic [9:0]    mirror_offset;
      unit_mask_type mirror_mask;
   } cfg_type;

   // Per-request information carried down the pipeline.
   typedef struct packed {
      kind_type              kind;
      logic [TYPE_COUNT-1:0] coinc;
      logic [TYPE_COUNT-1:0] single;
      logic [TYPE_COUNT-1:0] few_hits;
      logic                  fill;
      logic                  dx_neg;
      logic [MAG_W-1:0]      dx_mag;
      logic                  dy_neg;
      logic [MAG_W-1:0]      dy_mag;
      logic [15:0]           read_index;
      logic                  hist_ok;
      logic [31:0]           cnt_value;
   } item_type;

endpackage

// ===== rtl/dch_classifier.sv =====
// Unit report store, coincidence classification, event counters and position differences.
module dch_classifier import dch_pkg::*; #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  logic     adv,
   input  req_type  req,
   input  cfg_type  cfg,
   output logic     has_result,
   output item_type s1
);

   unit_rec_type rec_ff [UNIT_COUNT];
   unit_rec_type eff [UNIT_COUNT];
   logic [COUNT_WIDTH-1:0] cnt_ff [COUNTER_NUM];
   logic [COUNTER_NUM-1:0] cnt_inc;
   logic [UNIT_COUNT-1:0] present_u;
   logic [UNIT_COUNT-1:0] single_u;
   logic [UNIT_COUNT-1:0] few_hits_u;
   logic [TYPE_COUNT-1:0] coinc_t;
   logic [TYPE_COUNT-1:0] single_t;
   logic [TYPE_COUNT-1:0] few_hits_t;
   logic is_report;
   logic ev_close;
   unit_idx_type unit_a;
   unit_idx_type unit_b;
   logic signed [11:0] mx_a;
   logic signed [11:0] mx_b;
   logic signed [11:0] dx;
   logic signed [11:0] dy;
   logic signed [11:0] dx_abs;
   logic signed [11:0] dy_abs;
   logic [31:0] cnt_read;
   item_type s1_in;
   item_type s1_ff;

   // Mirrored X position of one unit, as a signed value.
   function automatic logic signed [11:0] mirror_x(input logic en, input logic [9:0] offset,
                                                   input logic [9:0] x);
      logic signed [11:0] xs;
      xs = signed'({2'b00, x});
      if (en) begin
         return signed'({2'b00, offset}) - xs;
      end
      return xs;
   endfunction

   assign is_report = (req.opcode == OP_REPORT);
   assign ev_close = accept && is_report && req.event_end;

   // The report being accepted takes part in its own event.
   always_comb begin
      for (int u = 0; u < UNIT_COUNT; u++) begin
         eff[u] = (is_report && req.unit == 2'(u)) ? req.rec : rec_ff[u];
      end
   end

   // Per-unit cut results.
   always_comb begin
      for (int u = 0; u < UNIT_COUNT; u++) begin
         present_u[u] = (eff[u].data_count != 8'd0);
         single_u[u] = (eff[u].x_clusters == 8'd1) && (eff[u].y_clusters == 8'd1);
         few_hits_u[u] = (eff[u].x_hits <= cfg.max_hits) && (eff[u].y_hits <= cfg.max_hits);
      end
   end

   // Coincidence flags per type; each cut builds on the previous one.
   always_comb begin
      for (int t = 0; t < TYPE_COUNT; t++) begin
         coinc_t[t] = ((present_u & TYPE_UNITS[t]) == TYPE_UNITS[t]);
         single_t[t] = coinc_t[t] && ((single_u & TYPE_UNITS[t]) == TYPE_UNITS[t]);
         few_hits_t[t] = single_t[t] && ((few_hits_u & TYPE_UNITS[t]) == TYPE_UNITS[t]);
      end
   end

   // Counter increments for a closing event.
   always_comb begin
      cnt_inc = '0;
      for (int t = 0; t < TYPE_COUNT; t++) begin
         cnt_inc[CNT_COINC_BASE + t] = ev_close && coinc_t[t];
         cnt_inc[CNT_SINGLE_BASE + t] = ev_close && single_t[t];
         cnt_inc[CNT_FEW_HITS_BASE + t] = ev_close && few_hits_t[t];
      end
      cnt_inc[CNT_EVENTS] = ev_close;
   end

   // Position differences of the selected pair.
   assign unit_a = FIRST_UNIT[cfg.pair_select];
   assign unit_b = SECOND_UNIT[cfg.pair_select];
   assign mx_a = mirror_x(cfg.mirror_mask[unit_a], cfg.mirror_offset, eff[unit_a].x_center);
   assign mx_b = mirror_x(cfg.mirror_mask[unit_b], cfg.mirror_offset, eff[unit_b].x_center);
   assign dx = mx_a - mx_b;
   assign dy = signed'({2'b00, eff[unit_a].y_center}) - signed'({2'b00, eff[unit_b].y_center});
   assign dx_abs = dx[11] ? -dx : dx;
   assign dy_abs = dy[11] ? -dy : dy;

   // Counter read port.
   always_comb begin
      if (req.read_index < 16'(COUNTER_NUM)) begin
         cnt_read = 32'(cnt_ff[req.read_index[3:0]]);
      end else begin
         cnt_read = '0;
      end
   end

   // Request decode.
   always_comb begin
      s1_in = '0;
      s1_in.read_index = req.read_index;
      has_result = 1'b0;
      unique case (req.opcode) inside
         OP_REPORT: begin
            has_result = req.event_end;
            s1_in.kind = KIND_EVENT;
            s1_in.coinc = coinc_t;
            s1_in.single = single_t;
            s1_in.few_hits = few_hits_t;
            s1_in.fill = few_hits_t[cfg.pair_select];
            s1_in.dx_neg = dx[11];
            s1_in.dx_mag = dx_abs[MAG_W-1:0];
            s1_in.dy_neg = dy[11];
            s1_in.dy_mag = dy_abs[MAG_W-1:0];
         end
         OP_HIST_READ: begin
            has_result = 1'b1;
            s1_in.kind = KIND_HIST;
         end
         OP_COUNTER_READ: begin
            has_result = 1'b1;
            s1_in.kind = KIND_COUNTER;
            s1_in.cnt_value = cnt_read;
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   // Report store and event counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int u = 0; u < UNIT_COUNT; u++) begin
            rec_ff[u] <= '0;
         end
         for (int i = 0; i < COUNTER_NUM; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         if (accept && is_report) begin
            if (req.event_end) begin
               for (int u = 0; u < UNIT_COUNT; u++) begin
                  rec_ff[u] <= '0;
               end
            end else if (req.unit < 2'(UNIT_COUNT)) begin
               rec_ff[req.unit] <= req.rec;
            end
         end
         for (int i = 0; i < COUNTER_NUM; i++) begin
            if (cnt_inc[i] && (cnt_ff[i] != '1)) begin
               cnt_ff[i] <= cnt_ff[i] + 1'b1;
            end
         end
      end
   end

   // First pipeline stage.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
      end
   end

   assign s1 = s1_ff;

endmodule

// ===== rtl/dch_bin_calc.sv =====
// Division of the position differences, clamping and histogram cell address.
module dch_bin_calc import dch_pkg::*; #(
   parameter int HALF_RANGE  = 99,
   parameter int BIN_DIVISOR = 10,
   localparam int SIDE = 2 * HALF_RANGE + 1,
   localparam int HIST_CELLS = SIDE * SIDE,
   localparam int COORD_W = $clog2(SIDE),
   localparam int ADDR_W = $clog2(HIST_CELLS)
) (
   input  logic                clock,
   input  logic                adv,
   input  item_type            s1,
   output item_type            s3,
   output logic [COORD_W-1:0]  s3_col,
   output logic [COORD_W-1:0]  s3_row,
   output logic [ADDR_W-1:0]   s3_addr
);

   // The magnitude is below 2^11 and the divisor below 2^7, so a shift of 18 makes the
   // rounded-up reciprocal exact for every magnitude.
   localparam int DIV_SHIFT = 18;
   localparam int RECIP_W = DIV_SHIFT + 1;
   localparam int PROD_W = MAG_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((2 ** DIV_SHIFT + BIN_DIVISOR - 1) / BIN_DIVISOR);
   localparam logic [COORD_W-1:0] HR_C = COORD_W'(HALF_RANGE);
   localparam logic [MAG_W-1:0] HR_M = MAG_W'(HALF_RANGE);
   localparam logic [ADDR_W-1:0] SIDE_A = ADDR_W'(SIDE);

   logic [PROD_W-1:0] prod_x;
   logic [PROD_W-1:0] prod_y;
   item_type s2_in;
   item_type s2_ff;
   logic [MAG_W-1:0] qx_ff;
   logic [MAG_W-1:0] qy_ff;
   logic [COORD_W-1:0] qcx;
   logic [COORD_W-1:0] qcy;
   logic [COORD_W-1:0] col_in;
   logic [COORD_W-1:0] row_in;
   logic [ADDR_W-1:0] addr_in;
   item_type s3_ff;
   logic [COORD_W-1:0] col_ff;
   logic [COORD_W-1:0] row_ff;
   logic [ADDR_W-1:0] addr_ff;

   // Quotient of each magnitude by reciprocal multiplication.
   assign prod_x = PROD_W'(s1.dx_mag) * PROD_W'(RECIP);
   assign prod_y = PROD_W'(s1.dy_mag) * PROD_W'(RECIP);

   // Histogram read range check.
   always_comb begin
      s2_in = s1;
      s2_in.hist_ok = (32'(s1.read_index) < 32'(HIST_CELLS));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff <= s2_in;
         qx_ff <= prod_x[DIV_SHIFT +: MAG_W];
         qy_ff <= prod_y[DIV_SHIFT +: MAG_W];
      end
   end

   // Clamp, restore the sign about the histogram centre, and form the cell address.
   assign qcx = (qx_ff > HR_M) ? HR_C : qx_ff[COORD_W-1:0];
   assign qcy = (qy_ff > HR_M) ? HR_C : qy_ff[COORD_W-1:0];
   assign col_in = s2_ff.dx_neg ? (HR_C - qcx) : (HR_C + qcx);
   assign row_in = s2_ff.dy_neg ? (HR_C - qcy) : (HR_C + qcy);

   always_comb begin
      if (s2_ff.kind == KIND_HIST) begin
         addr_in = s2_ff.hist_ok ? ADDR_W'(s2_ff.read_index) : '0;
      end else begin
         addr_in = ADDR_W'(row_in) * SIDE_A + ADDR_W'(col_in);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ff <= s2_ff;
         col_ff <= col_in;
         row_ff <= row_in;
         addr_ff <= addr_in;
      end
   end

   assign s3 = s3_ff;
   assign s3_col = col_ff;
   assign s3_row = row_ff;
   assign s3_addr = addr_ff;

endmodule

// ===== rtl/dch_hist_store.sv =====
// Histogram memory with read-modify-write, write forwarding, clearing pass and peak tracking.
module dch_hist_store import dch_pkg::*; #(
   parameter int HALF_RANGE  = 99,
   parameter int COUNT_WIDTH = 32,
   localparam int SIDE = 2 * HALF_RANGE + 1,
   localparam int HIST_CELLS = SIDE * SIDE,
   localparam int COORD_W = $clog2(SIDE),
   localparam int ADDR_W = $clog2(HIST_CELLS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   s4_valid,
   input  item_type               s3,
   input  logic [COORD_W-1:0]     s3_col,
   input  logic [COORD_W-1:0]     s3_row,
   input  logic [ADDR_W-1:0]      s3_addr,
   output logic                   busy,
   output item_type               s4,
   output logic [COORD_W-1:0]     s4_col,
   output logic [COORD_W-1:0]     s4_row,
   output logic [COUNT_WIDTH-1:0] cell_value,
   output logic [COUNT_WIDTH-1:0] new_count,
   output logic [COUNT_WIDTH-1:0] peak_next
);

   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(HIST_CELLS - 1);

   logic [COUNT_WIDTH-1:0] mem [HIST_CELLS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [COUNT_WIDTH-1:0] fwd_data_ff;
   logic [COUNT_WIDTH-1:0] peak_ff;
   item_type s4_ff;
   logic [COORD_W-1:0] col_ff;
   logic [COORD_W-1:0] row_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic fill_now;
   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;

   assign fill_now = adv && s4_valid && s4_ff.fill;

   // The write of the previous stage-four request landed at the same edge as this read.
   assign cell_value = (fwd_valid_ff && (fwd_addr_ff == addr_ff)) ? fwd_data_ff : rd_data_ff;
   assign new_count = (cell_value == '1) ? cell_value : cell_value + 1'b1;
   assign peak_next = (s4_ff.fill && (new_count > peak_ff)) ? new_count : peak_ff;

   // One write port, shared by the clearing pass and the bin increment.
   assign wr_en = clr_busy_ff || fill_now;
   assign wr_addr = clr_busy_ff ? clr_addr_ff : addr_ff;
   assign wr_data = clr_busy_ff ? '0 : new_count;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (adv) begin
         rd_data_ff <= mem[s3_addr];
      end
   end

   // Clearing pass, forwarding valid and peak register.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         fwd_valid_ff <= 1'b0;
         peak_ff <= '0;
      end else begin
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_CELL) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (adv) begin
            fwd_valid_ff <= fill_now;
            if (s4_valid) begin
               peak_ff <= peak_next;
            end
         end
      end
   end

   // Forwarding data and stage-four registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_addr_ff <= addr_ff;
         fwd_data_ff <= new_count;
         s4_ff <= s3;
         col_ff <= s3_col;
         row_ff <= s3_row;
         addr_ff <= s3_addr;
      end
   end

   assign busy = clr_busy_ff;
   assign s4 = s4_ff;
   assign s4_col = col_ff;
   assign s4_row = row_ff;

endmodule

// ===== rtl/detector_coincidence_histogrammer_core.sv =====
// Coincidence histogrammer core: one request per cycle while req_ready is high.
//
// The core accepts one request in every cycle while req_ready is high, that is outside the
// clearing pass and unless a result waits on a full output register. Unit reports are stored
// until the report that closes the event; that report classifies the coincidences, advances
// the matching ones of the thirteen event counters and, when the selected type passes all
// cuts, increments one cell of the position histogram. Every request that gives a result (a
// closing report, a histogram read or a counter read) presents it on the result channel
// through a four-stage pipeline and an output register; results leave in request order. The
// histogram lives in a synchronous memory with a registered read: the cell is read in stage
// three and written back in stage four, and a forwarding register covers back-to-back
// increments of the same cell. After reset the core clears all (2*HALF_RANGE+1)^2 cells of
// the histogram (39601 at the default setting), one cell per cycle; req_ready stays low
// during that pass, while configuration writes are taken as ever.
module detector_coincidence_histogrammer_core import dch_pkg::*; #(
   parameter int HALF_RANGE  = 99,
   parameter int BIN_DIVISOR = 10,
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [1:0]  req_unit,
   input  logic [7:0]  req_data_count,
   input  logic [7:0]  req_x_hits,
   input  logic [7:0]  req_x_clusters,
   input  logic [9:0]  req_x_center,
   input  logic [7:0]  req_y_hits,
   input  logic [7:0]  req_y_clusters,
   input  logic [9:0]  req_y_center,
   input  logic        req_event_end,
   input  logic [15:0] req_read_index,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [3:0]  rsp_coinc_flags,
   output logic [3:0]  rsp_single_cluster_flags,
   output logic [3:0]  rsp_small_hit_flags,
   output logic        rsp_filled,
   output logic [7:0]  rsp_bin_column,
   output logic [7:0]  rsp_bin_row,
   output logic [31:0] rsp_bin_count,
   output logic [31:0] rsp_peak_count,
   output logic [31:0] rsp_read_value,
   // Configuration port.
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   localparam int SIDE = 2 * HALF_RANGE + 1;
   localparam int HIST_CELLS = SIDE * SIDE;
   localparam int COORD_W = $clog2(SIDE);
   localparam int ADDR_W = $clog2(HIST_CELLS);

   localparam logic [1:0] REG_PAIR_SELECT = 2'd0;
   localparam logic [1:0] REG_MAX_HITS = 2'd1;
   localparam logic [1:0] REG_MIRROR_OFFSET = 2'd2;
   localparam logic [1:0] REG_MIRROR_MASK = 2'd3;

   cfg_type cfg_ff;
   req_type req;
   logic accept;
   logic adv;
   logic busy;
   logic has_result;
   logic v1_ff;
   logic v2_ff;
   logic v3_ff;
   logic v4_ff;
   item_type s1;
   item_type s3;
   item_type s4;
   logic [COORD_W-1:0] s3_col;
   logic [COORD_W-1:0] s3_row;
   logic [ADDR_W-1:0] s3_addr;
   logic [COORD_W-1:0] s4_col;
   logic [COORD_W-1:0] s4_row;
   logic [COUNT_WIDTH-1:0] cell_value;
   logic [COUNT_WIDTH-1:0] new_count;
   logic [COUNT_WIDTH-1:0] peak_next;

   logic        out_valid_ff;
   logic [1:0]  out_kind_ff;
   logic [3:0]  out_coinc_ff;
   logic [3:0]  out_single_ff;
   logic [3:0]  out_few_hits_ff;
   logic        out_filled_ff;
   logic [7:0]  out_col_ff;
   logic [7:0]  out_row_ff;
   logic [31:0] out_bin_count_ff;
   logic [31:0] out_peak_ff;
   logic [31:0] out_read_value_ff;
   logic [31:0] read_value_in;

   // Gather the request fields.
   always_comb begin
      req.opcode = req_opcode;
      req.unit = req_unit;
      req.rec.data_count = req_data_count;
      req.rec.x_hits = req_x_hits;
      req.rec.x_clusters = req_x_clusters;
      req.rec.x_center = req_x_center;
      req.rec.y_hits = req_y_hits;
      req.rec.y_clusters = req_y_clusters;
      req.rec.y_center = req_y_center;
      req.event_end = req_event_end;
      req.read_index = req_read_index;
   end

   // The pipeline moves unless a finished result in stage four meets a full output register and rsp_ready is low.
   assign adv = !v4_ff || !out_valid_ff || rsp_ready;
   assign req_ready = adv && !busy;
   assign accept = req_valid && req_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pair_select <= 2'd0;
         cfg_ff.max_hits <= 8'd3;
         cfg_ff.mirror_offset <= 10'd990;
         cfg_ff.mirror_mask <= 3'b011;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_PAIR_SELECT:   cfg_ff.pair_select <= csr_wdata[1:0];
            REG_MAX_HITS:      cfg_ff.max_hits <= csr_wdata[7:0];
            REG_MIRROR_OFFSET: cfg_ff.mirror_offset <= csr_wdata;
            REG_MIRROR_MASK:   cfg_ff.mirror_mask <= csr_wdata[2:0];
         endcase
      end
   end

   dch_classifier #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_classifier (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .adv       (adv),
      .req       (req),
      .cfg       (cfg_ff),
      .has_result(has_result),
      .s1        (s1)
   );

   dch_bin_calc #(
      .HALF_RANGE (HALF_RANGE),
      .BIN_DIVISOR(BIN_DIVISOR)
   ) u_bin_calc (
      .clock  (clock),
      .adv    (adv),
      .s1     (s1),
      .s3     (s3),
      .s3_col (s3_col),
      .s3_row (s3_row),
      .s3_addr(s3_addr)
   );

   dch_hist_store #(
      .HALF_RANGE (HALF_RANGE),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_hist_store (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .s4_valid  (v4_ff),
      .s3        (s3),
      .s3_col    (s3_col),
      .s3_row    (s3_row),
      .s3_addr   (s3_addr),
      .busy      (busy),
      .s4        (s4),
      .s4_col    (s4_col),
      .s4_row    (s4_row),
      .cell_value(cell_value),
      .new_count (new_count),
      .peak_next (peak_next)
   );

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= accept && has_result;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Value read by a histogram or counter request.
   always_comb begin
      case (s4.kind)
         KIND_HIST:    read_value_in = s4.hist_ok ? 32'(cell_value) : '0;
         KIND_COUNTER: read_value_in = s4.cnt_value;
         default:      read_value_in = '0;
      endcase
   end

   // Output register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv && v4_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (adv && v4_ff) begin
         out_kind_ff <= s4.kind;
         out_coinc_ff <= s4.coinc;
         out_single_ff <= s4.single;
         out_few_hits_ff <= s4.few_hits;
         out_filled_ff <= s4.fill;
         out_col_ff <= s4.fill ? 8'(s4_col) : '0;
         out_row_ff <= s4.fill ? 8'(s4_row) : '0;
         out_bin_count_ff <= s4.fill ? 32'(new_count) : '0;
         out_peak_ff <= (s4.kind == KIND_EVENT) ? 32'(peak_next) : '0;
         out_read_value_ff <= read_value_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_coinc_flags = out_coinc_ff;
   assign rsp_single_cluster_flags = out_single_ff;
   assign rsp_small_hit_flags = out_few_hits_ff;
   assign rsp_filled = out_filled_ff;
   assign rsp_bin_column = out_col_ff;
   assign rsp_bin_row = out_row_ff;
   assign rsp_bin_count = out_bin_count_ff;
   assign rsp_peak_count = out_peak_ff;
   assign rsp_read_value = out_read_value_ff;

endmodule
